// ===== hdl/ita_pkg.sv =====
`default_nettype none

package ita_pkg;

  // Value width and derived index widths
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(VALUE_WIDTH);
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);

  // Field widths fixed by the interface
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 7;

  // Radix clamp limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // ASCII codes
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'h30;
  localparam logic [CHAR_W-1:0] NINE_CHAR  = 7'h39;
  localparam logic [CHAR_W-1:0] UPPER_A    = 7'h41;
  localparam logic [CHAR_W-1:0] UPPER_F    = 7'h46;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  // Digit store write request
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [DIGIT_W-1:0] digit;
  } digit_wr_t;

  // Emission start request
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
    logic             minus;
  } emit_req_t;

  // Digit value to upper-case ASCII glyph
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] digit);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(digit);
    if (digit < DIGIT_TEN) begin
      glyph = ZERO_CHAR + ext;
    end else begin
      glyph = UPPER_A + ext - CHAR_W'(DIGIT_TEN);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_to_ascii_radix.sv =====
// Each digit is one full bit-serial pass of the divider over the dividend; digits are
// written to the digit store least significant first and emitted most significant first.
// Each digit character goes through FETCH, LOAD and HOLD, and stays in HOLD while stalled.
// Throughput: one request at a time; the next is taken once its last character has gone.
// Reset (rst_ni low, asynchronous) clears all control state; the digit store is not cleared.
`default_nettype none

module integer_to_ascii_radix (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [ita_pkg::VALUE_WIDTH-1:0] value_i,
  input  wire logic [ita_pkg::RADIX_W-1:0]            radix_i,
  input  wire logic                                   signed_mode_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [ita_pkg::CHAR_W-1:0]                  character_o,
  output logic                                        last_char_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic                                state_q, state_d;
  logic [ita_pkg::CNT_W-1:0]           count_q, count_d;
  logic [ita_pkg::RADIX_W-1:0]         radix_q, radix_d;
  logic                                minus_q, minus_d;
  logic                                accept;
  logic [ita_pkg::VALUE_WIDTH-1:0]     val_u;
  logic [ita_pkg::VALUE_WIDTH-1:0]     mag;
  logic                                neg;
  logic [ita_pkg::RADIX_W-1:0]         radix_clamped;
  logic [ita_pkg::CNT_W-1:0]           count_inc;
  logic                                div_start;
  logic [ita_pkg::VALUE_WIDTH-1:0]     div_dividend;
  logic                                div_done;
  logic [ita_pkg::VALUE_WIDTH-1:0]     div_quot;
  logic [ita_pkg::DIGIT_W-1:0]         div_rem;
  logic                                div_quot_nz;
  logic                                emit_busy;
  ita_pkg::digit_wr_t                  digit_wr;
  ita_pkg::emit_req_t                  emit_req;

  // Request handshake: one number in flight
  assign in_stall_o = (state_q != S_IDLE) || emit_busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Sign handling and radix clamp
  assign val_u = value_i;
  assign neg   = signed_mode_i && val_u[ita_pkg::VALUE_WIDTH-1];
  assign mag   = neg ? (~val_u + ita_pkg::VALUE_WIDTH'(1)) : val_u;

  always_comb begin
    priority if (radix_i < ita_pkg::RADIX_MIN) begin
      radix_clamped = ita_pkg::RADIX_MIN;
    end else if (radix_i > ita_pkg::RADIX_MAX) begin
      radix_clamped = ita_pkg::RADIX_MAX;
    end else begin
      radix_clamped = radix_i;
    end
  end

  assign count_inc = count_q + ita_pkg::CNT_W'(1);

  // Digit generation sequencer
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    radix_d        = radix_q;
    minus_d        = minus_q;
    div_start      = 1'b0;
    div_dividend   = div_quot;
    digit_wr.en    = 1'b0;
    digit_wr.addr  = count_q[ita_pkg::IDX_W-1:0];
    digit_wr.digit = div_rem;
    emit_req.start = 1'b0;
    emit_req.count = count_inc;
    emit_req.minus = minus_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          radix_d      = radix_clamped;
          minus_d      = neg;
          count_d      = '0;
          div_start    = 1'b1;
          div_dividend = mag;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          digit_wr.en = 1'b1;
          count_d     = count_inc;
          if (div_quot_nz && (count_inc < ita_pkg::CNT_W'(ita_pkg::VALUE_WIDTH))) begin
            div_start = 1'b1;
          end else begin
            emit_req.start = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      minus_q <= 1'b0;
      radix_q <= ita_pkg::RADIX_MIN;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      minus_q <= minus_d;
      radix_q <= radix_d;
    end
  end

  ita_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .radix_i    (radix_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .quot_nz_o  (div_quot_nz)
  );

  ita_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (digit_wr),
    .req_i       (emit_req),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

// ===== hdl/ita_divider.sv =====
`default_nettype none

// Bit-serial restoring divider: one dividend bit per cycle, small remainder
module ita_divider (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [ita_pkg::VALUE_WIDTH-1:0]     dividend_i,
  input  wire logic [ita_pkg::RADIX_W-1:0]         radix_i,
  output logic                                     done_o,
  output logic [ita_pkg::VALUE_WIDTH-1:0]          quot_o,
  output logic [ita_pkg::DIGIT_W-1:0]              rem_o,
  output logic                                     quot_nz_o
);

  logic                                 busy_q, busy_d;
  logic                                 done_q, done_d;
  logic [ita_pkg::IDX_W-1:0]            cnt_q, cnt_d;
  logic [ita_pkg::VALUE_WIDTH-1:0]      div_q, div_d;
  logic [ita_pkg::DIGIT_W-1:0]          rem_q, rem_d;
  logic                                 nz_q, nz_d;
  logic [ita_pkg::RADIX_W-1:0]          rem_shift;
  logic [ita_pkg::RADIX_W-1:0]          rem_sub;
  logic                                 qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_q, div_q[ita_pkg::VALUE_WIDTH-1]};
  assign qbit      = (rem_shift >= radix_i);
  assign rem_sub   = rem_shift - radix_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    nz_d   = nz_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = dividend_i;
      rem_d  = '0;
      nz_d   = 1'b0;
    end else if (busy_q) begin
      div_d = {div_q[ita_pkg::VALUE_WIDTH-2:0], qbit};
      rem_d = qbit ? rem_sub[ita_pkg::DIGIT_W-1:0] : rem_shift[ita_pkg::DIGIT_W-1:0];
      nz_d  = nz_q | qbit;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ita_pkg::IDX_W'(ita_pkg::VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    nz_q  <= nz_d;
  end

  assign done_o    = done_q;
  assign quot_o    = div_q;
  assign rem_o     = rem_q;
  assign quot_nz_o = nz_q;

endmodule

`default_nettype wire

// ===== hdl/ita_emitter.sv =====
`default_nettype none

// Digit store and character output stage, most significant digit first
module ita_emitter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ita_pkg::digit_wr_t           wr_i,
  input  wire ita_pkg::emit_req_t           req_i,
  output logic                              busy_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ita_pkg::CHAR_W-1:0]        character_o,
  output logic                              last_char_o
);

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_FETCH = 2'd1;
  localparam logic [1:0] E_LOAD  = 2'd2;
  localparam logic [1:0] E_HOLD  = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [ita_pkg::CNT_W-1:0]       k_q, k_d;
  logic                            valid_q, valid_d;
  logic [ita_pkg::CHAR_W-1:0]      char_q, char_d;
  logic                            last_q, last_d;
  logic [ita_pkg::DIGIT_W-1:0]     rd_data_q;
  logic [ita_pkg::CNT_W-1:0]       k_dec;
  logic [ita_pkg::IDX_W-1:0]       rd_addr;
  logic [ita_pkg::DIGIT_W-1:0]     store_mem [ita_pkg::VALUE_WIDTH];

  assign k_dec   = k_q - ita_pkg::CNT_W'(1);
  assign rd_addr = k_dec[ita_pkg::IDX_W-1:0];

  // Digit store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_mem[wr_i.addr] <= wr_i.digit;
    end
    if (state_q == E_FETCH) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  // Emission sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    unique case (state_q)
      E_IDLE: begin
        if (req_i.start) begin
          k_d = req_i.count;
          if (req_i.minus) begin
            char_d  = ita_pkg::MINUS_CHAR;
            last_d  = 1'b0;
            valid_d = 1'b1;
            state_d = E_HOLD;
          end else begin
            state_d = E_FETCH;
          end
        end
      end
      E_FETCH: begin
        state_d = E_LOAD;
      end
      E_LOAD: begin
        char_d  = ita_pkg::glyph(rd_data_q);
        last_d  = (k_q == ita_pkg::CNT_W'(1));
        valid_d = 1'b1;
        k_d     = k_dec;
        state_d = E_HOLD;
      end
      E_HOLD: begin
        if (!out_stall_i) begin
          valid_d = 1'b0;
          state_d = (k_q == '0) ? E_IDLE : E_FETCH;
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != E_IDLE);
  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

// ===== hdl/ita_checker.sv =====
`default_nettype none

// Port-level checks on the converter
module ita_checker (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   in_valid_i,
  input wire logic                                   in_stall_o,
  input wire logic signed [ita_pkg::VALUE_WIDTH-1:0] value_i,
  input wire logic [ita_pkg::RADIX_W-1:0]            radix_i,
  input wire logic                                   signed_mode_i,
  input wire logic                                   out_valid_o,
  input wire logic                                   out_stall_i,
  input wire logic [ita_pkg::CHAR_W-1:0]             character_o,
  input wire logic                                   last_char_o
);

  // A stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o) && $stable(last_char_o))
    else $error("stalled character changed");

  // No new request is taken while characters are still going out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken during emission");

  // No character is out while a fresh request is taken, nor straight after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !out_valid_o ##1 !out_valid_o)
    else $error("character too soon after request");

  // A minus sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (character_o == ita_pkg::MINUS_CHAR) |-> !last_char_o)
    else $error("minus marked as last");

  // Only digits, upper-case A to F or minus are emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((character_o >= ita_pkg::ZERO_CHAR) && (character_o <= ita_pkg::NINE_CHAR)) ||
      ((character_o >= ita_pkg::UPPER_A) && (character_o <= ita_pkg::UPPER_F)) ||
      (character_o == ita_pkg::MINUS_CHAR))
    else $error("illegal character");

endmodule

bind integer_to_ascii_radix ita_checker u_ita_checker (.*);

`default_nettype wire

// ===== tb/sv/integer_to_ascii_radix_test.sv =====
`default_nettype none

module integer_to_ascii_radix_test;
  import ita_pkg::*;

  // One emitted character as the block should present it
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // Glyphs in digit order, '0' in the top byte
  localparam logic [127:0] GLYPH_TABLE = "0123456789ABCDEF";

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [VALUE_WIDTH-1:0] value_i;
  logic [RADIX_W-1:0]            radix_i;
  logic                          signed_mode_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [CHAR_W-1:0]             character_o;
  logic                          last_char_o;

  text_char_t pending_chars [$];
  int         error_count = 0;
  bit         idling_on   = 1'b1;

  integer_to_ascii_radix dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .radix_i       (radix_i),
    .signed_mode_i (signed_mode_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .character_o   (character_o),
    .last_char_o   (last_char_o)
  );

  // 20-unit clock period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Random wait for a request or a taken character, zero during back-to-back stretches
  function automatic int pick_gap();
    return idling_on ? int'($urandom_range(0, 12)) : 0;
  endfunction

  // Queues the characters that one request should produce
  function automatic void render_number(logic [VALUE_WIDTH-1:0] value,
                                        logic [RADIX_W-1:0] radix, logic sgn);
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] base;
    logic [DIGIT_W-1:0]     digit_buf [VALUE_WIDTH];
    text_char_t             tc;
    int                     n;
    base = (radix < RADIX_MIN) ? VALUE_WIDTH'(RADIX_MIN) :
           (radix > RADIX_MAX) ? VALUE_WIDTH'(RADIX_MAX) : VALUE_WIDTH'(radix);
    mag  = value;
    n    = 0;
    // Negative in signed mode: minus first, then the magnitude
    if (sgn && value[VALUE_WIDTH-1]) begin
      mag     = -value;
      tc.code = MINUS_CHAR;
      tc.last = 1'b0;
      pending_chars.push_back(tc);
    end
    // Digits least significant first; zero still gives one digit
    do begin
      digit_buf[n] = DIGIT_W'(mag % base);
      mag          = mag / base;
      n++;
    end while (mag != 0 && n < VALUE_WIDTH);
    for (int k = n - 1; k >= 0; k--) begin
      tc.code = CHAR_W'(GLYPH_TABLE[(15 - digit_buf[k]) * 8 +: 8]);
      tc.last = (k == 0);
      pending_chars.push_back(tc);
    end
  endfunction

  // Sends one request; returns just after the edge that took it
  task automatic send_number(logic [VALUE_WIDTH-1:0] value, logic [RADIX_W-1:0] radix,
                             logic sgn);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    value_i       <= value;
    radix_i       <= radix;
    signed_mode_i <= sgn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    render_number(value, radix, sgn);
  endtask

  // Holds off the sender until every queued character has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // Random request biased towards legal radices and varied magnitudes
  task automatic send_random();
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;
    case ($urandom_range(0, 4))
      0: value = $urandom;
      1: value = $urandom_range(0, 255);
      2: value = -$urandom_range(1, 300);
      3: value = $urandom >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 4))
          0: value = '0;
          1: value = 1;
          2: value = 32'h7FFF_FFFF;
          3: value = 32'h8000_0000;
          default: value = '1;
        endcase
      end
    endcase
    radix = ($urandom_range(0, 3) == 0) ? RADIX_W'($urandom_range(0, 31))
                                        : RADIX_W'($urandom_range(2, 16));
    send_number(value, radix, 1'($urandom_range(0, 1)));
  endtask

  // Zero prints a lone '0'
  task automatic test_zero();
    send_number('0, 5'd10, 1'b1);
    send_number('0, 5'd2, 1'b0);
    send_number('0, 5'd16, 1'b1);
  endtask

  // Extremes of the value, including the most negative number in full
  task automatic test_extremes();
    send_number(32'h7FFF_FFFF, 5'd10, 1'b1);
    send_number(32'h8000_0000, 5'd10, 1'b1);
    send_number(32'h8000_0000, 5'd2, 1'b1);
    send_number(32'hFFFF_FFFF, 5'd2, 1'b0);
    send_number(32'hFFFF_FFFF, 5'd10, 1'b1);
    send_number(32'hFFFF_FFFF, 5'd16, 1'b0);
    send_number(32'h8000_0000, 5'd16, 1'b0);
  endtask

  // Radix below two and above sixteen are clamped
  task automatic test_radix_clamp();
    send_number(32'h0001_2345, 5'd0, 1'b0);
    send_number(32'hFFFF_FF85, 5'd1, 1'b1);
    send_number(32'h0001_2345, 5'd17, 1'b0);
    send_number(32'hDEAD_BEEF, 5'd31, 1'b1);
  endtask

  // Every glyph and a few odd radices
  task automatic test_digit_glyphs();
    send_number(32'hFEDC_BA98, 5'd16, 1'b0);
    send_number(32'h0123_4567, 5'd16, 1'b1);
    send_number(32'h0000_0010, 5'd16, 1'b1);
    send_number(-32'sd1000, 5'd3, 1'b1);
    send_number(32'h0BAD_CAFE, 5'd7, 1'b0);
    send_number(-32'sd123456789, 5'd13, 1'b1);
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random();
  endtask

  // No idling on either side for a stretch
  task automatic test_back_to_back(int count);
    idling_on = 1'b0;
    repeat (count) send_random();
    idling_on = 1'b1;
  endtask

  // Character sink: draws a stall after each taken character and checks it
  initial begin
    int         hold;
    text_char_t exp_char;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected character expected none actual %h last %b",
                   $time, character_o, last_char_o);
          error_count++;
        end else begin
          exp_char = pending_chars.pop_front();
          if (character_o !== exp_char.code) begin
            $display("%0t: character expected %h actual %h",
                     $time, exp_char.code, character_o);
            error_count++;
          end
          if (last_char_o !== exp_char.last) begin
            $display("%0t: last_char expected %b actual %b",
                     $time, exp_char.last, last_char_o);
            error_count++;
          end
        end
        hold = pick_gap();
      end else if (hold > 0) begin
        hold--;
      end
      out_stall_i <= (hold != 0);
    end
  end

  // Stimulus sequence
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    radix_i       = '0;
    signed_mode_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero();
    test_extremes();
    test_radix_clamp();
    test_digit_glyphs();
    test_random_mix(100);
    wait_drained();
    test_back_to_back(40);
    test_random_mix(50);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== integer_to_ascii_radix.f =====
hdl/ita_pkg.sv
hdl/ita_divider.sv
hdl/ita_emitter.sv
hdl/integer_to_ascii_radix.sv
hdl/ita_checker.sv
tb/sv/integer_to_ascii_radix_test.sv
